>>> rtl/smt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// smt_pkg
// Shared types, operation and status codes, and the prefix mask function for
// the IPv4 subnet match table.
// ============================================================================
package smt_pkg;

    // Operation codes of a request.
    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Status codes of a result.
    localparam logic [1:0] ST_MATCH      = 2'd0;
    localparam logic [1:0] ST_NOMATCH    = 2'd1;
    localparam logic [1:0] ST_WRITTEN    = 2'd2;
    localparam logic [1:0] ST_UNATTACHED = 2'd3;

    // Field widths fixed by the interface.
    localparam int ADDR_W   = 32;
    localparam int IDX_W    = 4;
    localparam int PREFIX_W = 6;
    localparam int COUNT_W  = 5;

    // A request as it travels down the row of cells.
    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
        logic [1:0]        status;
        logic [IDX_W-1:0]  hit;
    } tok_t;

    // Netmask for a prefix length; zero matches everything, above 32 acts as 32.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] p);
        logic [PREFIX_W-1:0] q;
        begin
            q = (p > 6'd32) ? 6'd32 : p;
            if (q == '0)
            begin
                prefix_mask = '0;
            end
            else
            begin
                prefix_mask = {ADDR_W{1'b1}} << (6'd32 - q);
            end
        end
    endfunction

endpackage

>>> rtl/smt_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// smt_cell
// One table entry. Holds the entry's address, netmask and configured flag,
// applies a set or clear aimed at it, checks a passing lookup, and hands the
// request to the next cell.
// ============================================================================
module smt_cell #(
    parameter int CELL_ID = 0,
    parameter int LIVE_W  = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [LIVE_W-1:0]   live,
    input  logic                in_vld,
    input  smt_pkg::tok_t       in_tok,
    output logic                out_vld,
    output smt_pkg::tok_t       out_tok
);
    import smt_pkg::*;

    logic              vld_reg;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic              configured_reg;
    logic              configured_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] mask_reg;
    logic              in_range;
    logic              idx_sel;
    logic              hit_here;
    logic              wr_here;

    // This cell takes part only while its index is below the attached count.
    assign in_range = live > LIVE_W'(CELL_ID);
    assign idx_sel  = {{(LIVE_W-IDX_W){1'b0}}, in_tok.idx} == LIVE_W'(CELL_ID);

    // First-hit check: an earlier cell that matched has already set the status.
    assign hit_here = in_vld && (in_tok.op == OP_LOOKUP) && (in_tok.status == ST_NOMATCH)
                      && in_range && configured_reg
                      && ((in_tok.addr & mask_reg) == (addr_reg & mask_reg));

    // The entry stage has already screened the index against the attached count.
    assign wr_here = in_vld && ((in_tok.op == OP_SET) || (in_tok.op == OP_CLEAR))
                     && (in_tok.status == ST_WRITTEN) && idx_sel;

    // Update the travelling request.
    always_comb
    begin
        tok_next = in_tok;
        if (hit_here)
        begin
            tok_next.status = ST_MATCH;
            tok_next.hit    = IDX_W'(CELL_ID);
        end
    end

    always_comb
    begin
        configured_next = configured_reg;
        if (wr_here)
        begin
            configured_next = (in_tok.op == OP_SET);
        end
    end

    // Control state: stage valid and the configured flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= 1'b0;
            configured_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg        <= in_vld;
            configured_reg <= configured_next;
        end
    end

    // Payload: the forwarded request and the entry's address and mask.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
            if (wr_here && (in_tok.op == OP_SET))
            begin
                addr_reg <= in_tok.addr;
                mask_reg <= in_tok.mask;
            end
        end
    end

    assign out_vld = vld_reg;
    assign out_tok = tok_reg;

endmodule

>>> rtl/ipv4_subnet_match_table.sv
`timescale 1ns / 1ps
// ============================================================================
// ipv4_subnet_match_table
// Interface table with first-hit IPv4 subnet lookup over a row of entry cells.
// ============================================================================
// Each request (set, clear or lookup) walks a row of ENTRIES cells, and its
// result is registered after the last cell. The row is fully pipelined, so a
// new request is accepted every cycle while the result register is free or
// being drained; when results are not taken, the whole row holds. A lookup
// reports the lowest attached, configured entry whose subnet contains the
// query address; set and clear to an index at or above the attached count
// answer "not attached" and change nothing. The attached count is to be
// written through the configuration port while no request is in flight; the
// block itself does not enforce this.
module ipv4_subnet_match_table #(
    parameter int ENTRIES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [smt_pkg::COUNT_W-1:0]    cfg_data,
    // Request channel.
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     op,
    input  logic [smt_pkg::IDX_W-1:0]      entry_index,
    input  logic [smt_pkg::ADDR_W-1:0]     ip_addr,
    input  logic [smt_pkg::PREFIX_W-1:0]   prefix_len,
    // Result channel.
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [smt_pkg::IDX_W-1:0]      match_index
);
    import smt_pkg::*;

    localparam int LIVE_W = ($clog2(ENTRIES + 1) > COUNT_W) ? $clog2(ENTRIES + 1) : COUNT_W;

    logic [COUNT_W-1:0] count_reg;
    logic [LIVE_W-1:0]  count_ext;
    logic [LIVE_W-1:0]  live;
    logic               advance;
    logic               attached;
    tok_t               entry_tok;
    logic               chain_vld [0:ENTRIES];
    tok_t               chain_tok [0:ENTRIES];
    logic               out_vld_reg;
    logic [1:0]         status_reg;
    logic [IDX_W-1:0]   match_index_reg;

    // Attached-count register; always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            count_reg <= cfg_data;
        end
    end

    // Effective count, clamped to the table size.
    assign count_ext = LIVE_W'(count_reg);
    assign live      = (count_ext > LIVE_W'(ENTRIES)) ? LIVE_W'(ENTRIES) : count_ext;

    // The row moves whenever the result register can take a new value.
    assign advance  = !out_vld_reg || out_ready;
    assign in_ready = advance;

    // Entry stage: screen the write index and build the netmask.
    assign attached = {{(LIVE_W-IDX_W){1'b0}}, entry_index} < live;

    always_comb
    begin
        entry_tok.op   = op;
        entry_tok.idx  = entry_index;
        entry_tok.addr = ip_addr;
        entry_tok.mask = prefix_mask(prefix_len);
        entry_tok.hit  = '0;
        if ((op == OP_SET) || (op == OP_CLEAR))
        begin
            entry_tok.status = attached ? ST_WRITTEN : ST_UNATTACHED;
        end
        else
        begin
            entry_tok.status = ST_NOMATCH;
        end
    end

    assign chain_vld[0] = in_valid;
    assign chain_tok[0] = entry_tok;

    // Row of entry cells.
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        smt_cell #(
            .CELL_ID (g),
            .LIVE_W  (LIVE_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .live    (live),
            .in_vld  (chain_vld[g]),
            .in_tok  (chain_tok[g]),
            .out_vld (chain_vld[g+1]),
            .out_tok (chain_tok[g+1])
        );
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= chain_vld[ENTRIES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg      <= chain_tok[ENTRIES].status;
            match_index_reg <= chain_tok[ENTRIES].hit;
        end
    end

    assign out_valid   = out_vld_reg;
    assign status      = status_reg;
    assign match_index = match_index_reg;

endmodule

>>> rtl/smt_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// smt_checker
// Port-level checks for the IPv4 subnet match table, bound to the top level.
// ============================================================================
module smt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_ready,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    status,
    input logic [smt_pkg::IDX_W-1:0]     match_index
);
    import smt_pkg::*;

    // A held result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(match_index))
        else $error("result changed while stalled");

    // Only a matching lookup carries a nonzero index.
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_MATCH) |-> (match_index == '0))
        else $error("match index set without a match");

    // With no result waiting, the block must take a new request.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused while result register is empty");

    // A result that is taken frees the block for a request in the same cycle.
    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready && cfg_ready)
        else $error("request refused while result drains");

endmodule

bind ipv4_subnet_match_table smt_checker u_smt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ready   (cfg_ready),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .match_index (match_index)
);
